### rtl/etfp_pkg.sv
// shared types, constants and the crc-8 step for the telemetry frame parser
package etfp_pkg;

	localparam int unsigned FRAME_LEN   = 10;
	localparam int unsigned DATA_LEN    = FRAME_LEN - 1;
	localparam int unsigned COUNT_W     = 4;
	localparam int unsigned IN_DATA_W   = 8;
	localparam int unsigned OUT_FIELD_W = 8 + 4 * 16 + 1;
	localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam logic [7:0]  CRC_POLY    = 8'h07;
	localparam logic [7:0]  CRC_TOP     = 8'h80;

	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic        crc_error;
		logic [15:0] erpm_hundreds;
		logic [15:0] consumed_charge;
		logic [15:0] current;
		logic [15:0] voltage;
		logic [7:0]  temperature;
	} frame_t;

	typedef struct packed {
		logic   load;
		frame_t frame;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] v;
		v = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if ((v & CRC_TOP) != 8'h00) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

	function automatic logic [OUT_DATA_W-1:0] pack_frame(input frame_t f);
		logic [OUT_DATA_W-1:0] d;
		d = '0;
		d[OUT_FIELD_W-1:0] = {f.crc_error, f.erpm_hundreds, f.consumed_charge, f.current,
			f.voltage, f.temperature};
		return d;
	endfunction

endpackage

### rtl/esc_telemetry_frame_parser.sv
// Motor-controller telemetry frame parser, top level.
//
// Input channel s_axis carries one received serial byte per beat. Every ten
// bytes form a frame: bytes 0..8 are data, byte 9 is a crc-8 (poly 0x07,
// init 0, msb first) over them. On the tenth byte one decoded frame leaves
// on m_axis: temperature, big-endian voltage, current, consumed charge and
// erpm/100, plus a flag set when the crc byte does not match.
//
// A byte is held in the input register and is then folded into the counter
// and crc; the tenth byte is decoded from the input register into the output
// register, from which the frame leaves on m_axis. Throughput: one byte per
// cycle, set by the byte-wide crc step, unless a tenth byte waits on m_axis.
//
// Reset clears the byte counter, the crc and both valid flags; framing is
// counted from reset only. When m_axis stalls, data bytes keep flowing in;
// only a tenth byte waits in the input register until the output register
// frees, and s_axis_tready drops for that time.
module esc_telemetry_frame_parser
	import etfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// temperature, voltage, current, consumed_charge, erpm_hundreds, crc_error, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic                 advance;
	logic                 valid_s1;
	logic [IN_DATA_W-1:0] byte_s1;
	logic                 out_free;
	result_t              result;

	etfp_input_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1)
	);

	etfp_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.advance  (advance),
		.result   (result)
	);

	etfp_result_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.result        (result),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### rtl/etfp_input_reg.sv
// input register stage holding one received byte
module etfp_input_reg
	import etfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic                 advance,
	output logic                 valid_s1,
	output logic [IN_DATA_W-1:0] byte_s1
);

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

endmodule

### rtl/etfp_frame_core.sv
// byte counter, running crc and frame byte store
module etfp_frame_core
	import etfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic [IN_DATA_W-1:0] byte_s1,
	input  logic                 out_free,
	output logic                 advance,
	output result_t              result
);

	count_t     count_q;
	logic [7:0] crc_q;
	logic [7:0] store_q [DATA_LEN];
	logic       is_last;

	assign is_last = (count_q >= COUNT_W'(DATA_LEN));
	assign advance = valid_s1 && (!is_last || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= '0;
		end else if (advance) begin
			if (is_last) begin
				count_q <= '0;
				crc_q   <= '0;
			end else begin
				count_q <= count_q + COUNT_W'(1);
				crc_q   <= crc8_byte(crc_q, byte_s1);
			end
		end
	end

	// data bytes, always written before they are read within a frame
	always_ff @(posedge clk) begin
		if (advance && !is_last) begin
			store_q[count_q] <= byte_s1;
		end
	end

	always_comb begin
		result.load                  = advance && is_last;
		result.frame.temperature     = store_q[0];
		result.frame.voltage         = {store_q[1], store_q[2]};
		result.frame.current         = {store_q[3], store_q[4]};
		result.frame.consumed_charge = {store_q[5], store_q[6]};
		result.frame.erpm_hundreds   = {store_q[7], store_q[8]};
		result.frame.crc_error       = (crc_q != byte_s1);
	end

endmodule

### rtl/etfp_result_reg.sv
// output register for decoded frames
module etfp_result_reg
	import etfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  result_t               result,
	output logic                  out_free,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic valid_q;

	assign out_free      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.load) begin
			m_axis_tdata <= pack_frame(result.frame);
		end
	end

endmodule

### rtl/etfp_checker.sv
// port-level checks for the telemetry frame parser, bound to the top level
module etfp_checker
	import etfp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output beat changed");

	// input only backs up behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// pad bits above the fields are zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_FIELD_W] == '0)
		else $error("non-zero pad bits on output");

	// no frame straight out of reset
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	// offered input byte is known
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown(s_axis_tdata))
		else $error("unknown input byte offered");

endmodule

bind esc_telemetry_frame_parser etfp_checker u_etfp_checker (.*);
